### rtl/core/rnea_pkg.sv
// Shared types and constants for the ring neighbor exclusion arbiter.
// No dependencies; compiled first.
package rnea_pkg;

   localparam int SEAT_W  = 4;
   localparam int TOKEN_W = 4;

   localparam logic [TOKEN_W-1:0] TOKEN_MAX   = 4'd15;
   localparam logic [TOKEN_W-1:0] BOWL_RESET  = 4'd4;

   localparam logic ACT_REQUEST = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      SEAT_EATING   = 2'd0,
      SEAT_HUNGRY   = 2'd1,
      SEAT_THINKING = 2'd2
   } seat_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;          // latch the accepted item
      logic update;        // mark seat hungry / thinking, return token
      logic grant_first;   // test requester, or left neighbor on release
      logic grant_second;  // test right neighbor on release
      logic pop;           // result taken downstream
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic skip;          // item changes nothing
      logic is_release;
      logic has_result;
      logic one_left;
   } sts_type;

endpackage

### rtl/core/rnea_if.sv
// Channel interfaces: request, result and bowl count write.
// Depends on rnea_pkg.
interface rnea_req_if;
   import rnea_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [SEAT_W-1:0] seat;
   modport source (output valid, action, seat, input ready);
   modport sink   (input valid, action, seat, output ready);
endinterface

interface rnea_rsp_if;
   import rnea_pkg::*;
   logic               valid;
   logic               ready;
   logic [SEAT_W-1:0]  granted_seat;
   logic [TOKEN_W-1:0] tokens_left;
   logic               last;
   modport source (output valid, granted_seat, tokens_left, last, input ready);
   modport sink   (input valid, granted_seat, tokens_left, last, output ready);
endinterface

interface rnea_csr_if;
   import rnea_pkg::*;
   logic               valid;
   logic               ready;
   logic [TOKEN_W-1:0] bowl_count;
   modport source (output valid, bowl_count, input ready);
   modport sink   (input valid, bowl_count, output ready);
endinterface

### rtl/core/rnea_datapath.sv
// Seat state register file, token counter and two-entry result queue.
// Depends on rnea_pkg.
module rnea_datapath #(
   parameter int SEATS = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rnea_pkg::cmd_type              cmd,
   output rnea_pkg::sts_type              sts,
   input  logic                           req_action,
   input  logic [rnea_pkg::SEAT_W-1:0]    req_seat,
   input  logic                           csr_write,
   input  logic [rnea_pkg::TOKEN_W-1:0]   csr_bowl_count,
   output logic [rnea_pkg::SEAT_W-1:0]    rsp_granted_seat,
   output logic [rnea_pkg::TOKEN_W-1:0]   rsp_tokens_left,
   output logic                           rsp_last
);
   import rnea_pkg::*;

   localparam int SW = $clog2(SEATS);
   localparam logic [SW-1:0]     LAST_IDX   = SW'(SEATS - 1);
   localparam logic [SEAT_W:0]   SEAT_LIMIT = (SEAT_W + 1)'(SEATS);

   seat_state_type     status_ff [SEATS];
   seat_state_type     status_in [SEATS];
   logic               action_ff, action_in;
   logic [SEAT_W-1:0]  seat_ff, seat_in;
   logic [TOKEN_W-1:0] free_ff, free_in;
   logic [TOKEN_W-1:0] bowl_ff, bowl_in;
   logic [SEAT_W-1:0]  slot_seat_ff [2];
   logic [SEAT_W-1:0]  slot_seat_in [2];
   logic [TOKEN_W-1:0] slot_tok_ff [2];
   logic [TOKEN_W-1:0] slot_tok_in [2];
   logic [1:0]         count_ff, count_in;

   logic [SEATS-1:0]   eating, hungry, can_grant;
   logic [SW-1:0]      idx, left_idx, right_idx, cand;
   logic               seat_ok, grant_ok;

   // per-seat grant condition, each seat looks only at its fixed neighbors
   for (genvar i = 0; i < SEATS; i++) begin : g_seat
      assign eating[i]    = (status_ff[i] == SEAT_EATING);
      assign hungry[i]    = (status_ff[i] == SEAT_HUNGRY);
      assign can_grant[i] = hungry[i] && !eating[(i + SEATS - 1) % SEATS]
                            && !eating[(i + 1) % SEATS];
   end

   assign idx       = seat_ff[SW-1:0];
   assign seat_ok   = ({1'b0, seat_ff} < SEAT_LIMIT);
   assign left_idx  = (idx == '0) ? LAST_IDX : idx - 1'b1;
   assign right_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
   assign cand      = (action_ff == ACT_REQUEST) ? idx :
                      (cmd.grant_second ? right_idx : left_idx);
   assign grant_ok  = can_grant[cand] && (free_ff != '0);

   assign sts.skip       = !seat_ok || ((action_ff == ACT_REQUEST) && eating[idx]);
   assign sts.is_release = (action_ff == ACT_RELEASE);
   assign sts.has_result = (count_ff != 2'd0);
   assign sts.one_left   = (count_ff == 2'd1);

   assign rsp_granted_seat = slot_seat_ff[0];
   assign rsp_tokens_left  = slot_tok_ff[0];
   assign rsp_last         = (count_ff == 2'd1);

   always_comb begin
      status_in    = status_ff;
      action_in    = action_ff;
      seat_in      = seat_ff;
      free_in      = free_ff;
      bowl_in      = bowl_ff;
      slot_seat_in = slot_seat_ff;
      slot_tok_in  = slot_tok_ff;
      count_in     = count_ff;

      if (cmd.load) begin
         action_in = req_action;
         seat_in   = req_seat;
      end

      if (cmd.update && !sts.skip) begin
         if (action_ff == ACT_REQUEST) begin
            status_in[idx] = SEAT_HUNGRY;
         end else begin
            if (eating[idx] && (free_ff != TOKEN_MAX)) begin
               free_in = free_ff + 1'b1;
            end
            status_in[idx] = SEAT_THINKING;
         end
      end

      if ((cmd.grant_first || cmd.grant_second) && grant_ok) begin
         status_in[cand]           = SEAT_EATING;
         free_in                   = free_ff - 1'b1;
         slot_seat_in[count_ff[0]] = SEAT_W'(cand);
         slot_tok_in[count_ff[0]]  = free_ff - 1'b1;
         count_in                  = count_ff + 1'b1;
      end

      if (cmd.pop) begin
         slot_seat_in[0] = slot_seat_ff[1];
         slot_tok_in[0]  = slot_tok_ff[1];
         count_in        = count_ff - 1'b1;
      end

      // bowl count reloads the pool only while nobody holds a token
      if (csr_write) begin
         bowl_in = csr_bowl_count;
         if (!(|eating)) begin
            free_in = csr_bowl_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEATS; i++) begin
            status_ff[i] <= SEAT_THINKING;
         end
         free_ff  <= BOWL_RESET;
         bowl_ff  <= BOWL_RESET;
         count_ff <= 2'd0;
      end else begin
         status_ff <= status_in;
         free_ff   <= free_in;
         bowl_ff   <= bowl_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      seat_ff      <= seat_in;
      slot_seat_ff <= slot_seat_in;
      slot_tok_ff  <= slot_tok_in;
   end

endmodule

### rtl/core/rnea_ctrl.sv
// Sequencing state machine: accept, update, up to two grant tests, drain.
// Depends on rnea_pkg.
module rnea_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rnea_pkg::cmd_type cmd,
   input  rnea_pkg::sts_type sts
);
   import rnea_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_GRANT1 = 5'b00100,
      ST_GRANT2 = 5'b01000,
      ST_EMIT   = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_EMIT) && sts.has_result;
   assign cmd.load         = req_ready && req_valid;
   assign cmd.update       = (state_ff == ST_UPDATE);
   assign cmd.grant_first  = (state_ff == ST_GRANT1);
   assign cmd.grant_second = (state_ff == ST_GRANT2);
   assign cmd.pop          = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = sts.skip ? ST_IDLE : ST_GRANT1;
         end
         ST_GRANT1: begin
            state_in = sts.is_release ? ST_GRANT2 : ST_EMIT;
         end
         ST_GRANT2: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.has_result || (cmd.pop && sts.one_left)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/ring_neighbor_exclusion_arbiter_unit.sv
// Top level of the ring neighbor exclusion arbiter (shared-bowl seat ring).
// Depends on rnea_pkg, rnea_if, rnea_ctrl and rnea_datapath.
//
//   channel    dir  handshake      payload
//   req_chan   in   valid/ready    action (0 request, 1 release), seat
//   rsp_chan   out  valid/ready    granted_seat, tokens_left, last
//   csr_chan   in   valid/ready    bowl_count (ready always high)
//
// Sequencing: one item at a time, walked through by the controller. An ignored
//   item goes from the update state straight back to idle; a request gets one
//   grant test and a release two (left neighbor, then right), then the results
//   are drained. The grant tests run one neighbor per cycle on the seat
//   register file.
// Reset: synchronous; all seats thinking, bowl count and free tokens at 4.
// Stalls: rsp_chan back-pressure holds the result queue; no new item is
//   taken until every grant of the current one has been delivered.
module ring_neighbor_exclusion_arbiter_unit #(
   parameter int SEATS = 5
) (
   input logic        clock,
   input logic        reset,
   rnea_req_if.sink   req_chan,
   rnea_rsp_if.source rsp_chan,
   rnea_csr_if.sink   csr_chan
);
   import rnea_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register writes are always accepted; software writes only while idle (not enforced here)
   assign csr_chan.ready = 1'b1;

   rnea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rnea_datapath #(
      .SEATS (SEATS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_chan.action),
      .req_seat         (req_chan.seat),
      .csr_write        (csr_chan.valid),
      .csr_bowl_count   (csr_chan.bowl_count),
      .rsp_granted_seat (rsp_chan.granted_seat),
      .rsp_tokens_left  (rsp_chan.tokens_left),
      .rsp_last         (rsp_chan.last)
   );

endmodule

### rtl/core/rnea_checker.sv
// Port-level checks for the ring neighbor exclusion arbiter, with its bind.
// Depends on rnea_pkg and the top level.
module rnea_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rnea_pkg::SEAT_W-1:0]    rsp_granted_seat,
   input logic [rnea_pkg::TOKEN_W-1:0]   rsp_tokens_left,
   input logic                           rsp_last
);
   import rnea_pkg::*;

   // a grant always consumes a token, so the pool cannot read full afterward
   a_tokens_below_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tokens_left != TOKEN_MAX))
      else $error("grant reported with a full token pool");

   // one item in flight: no intake while results are pending
   a_no_intake_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item taken while a result waits");

   // an item needs at least an update and a test before any result
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result in the cycle after intake");

   // the second grant of an item follows right behind the first
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("second grant missing after a non-final result");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_granted_seat) && $stable(rsp_tokens_left)
          && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind ring_neighbor_exclusion_arbiter_unit rnea_checker u_rnea_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_granted_seat (rsp_chan.granted_seat),
   .rsp_tokens_left  (rsp_chan.tokens_left),
   .rsp_last         (rsp_chan.last)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ring_neighbor_exclusion_arbiter_unit.
// Depends on rnea_pkg, the rnea_*_if interfaces and the arbiter RTL.
module tb;
   import rnea_pkg::*;

   localparam int SEATS          = 5;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off in the last phase
   localparam int SETTLE_CYCLES  = 12;    // covers the slowest item with no grant

   typedef struct packed {
      logic              action;
      logic [SEAT_W-1:0] seat;
   } seat_cmd_type;

   typedef struct packed {
      logic [SEAT_W-1:0]  seat;
      logic [TOKEN_W-1:0] tokens;
      logic               last;
   } grant_type;

   logic clock;
   logic reset;

   rnea_req_if req_if ();
   rnea_rsp_if rsp_if ();
   rnea_csr_if csr_if ();

   ring_neighbor_exclusion_arbiter_unit #(.SEATS(SEATS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // stimulus and scoreboard
   seat_cmd_type pending_cmds[$];
   grant_type    expected_grants[$];
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   bit        hold_arm      = 1'b0;
   bit        req_fired     = 1'b0;
   int        fail_count    = 0;
   int        quiet_cycles  = 0;

   // receiver-owned hold-off state
   int        hold_left = 0;
   bit        hold_done = 1'b0;

   // shadow copy of the arbiter state
   seat_state_type     ring_state [SEATS];
   logic [TOKEN_W-1:0] free_bowls;
   logic [TOKEN_W-1:0] bowl_reg;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int left_seat(input int s);
      return (s + SEATS - 1) % SEATS;
   endfunction

   function automatic int right_seat(input int s);
      return (s + 1) % SEATS;
   endfunction

   // Grant seat s if it is hungry, both neighbors are not eating and a bowl is free.
   function automatic void offer_bowl(input int s);
      grant_type g;
      if (ring_state[s] == SEAT_HUNGRY &&
          ring_state[left_seat(s)] != SEAT_EATING &&
          ring_state[right_seat(s)] != SEAT_EATING &&
          free_bowls != '0) begin
         ring_state[s] = SEAT_EATING;
         free_bowls    = free_bowls - 1'b1;
         g.seat        = s[SEAT_W-1:0];
         g.tokens      = free_bowls;
         g.last        = 1'b0;
         expected_grants.push_back(g);
      end
   endfunction

   function automatic void predict_grants(input logic act, input logic [SEAT_W-1:0] seat);
      int        s;
      int        queued_n;
      grant_type g;
      s        = int'(seat);
      queued_n = expected_grants.size();
      if (s >= SEATS)
         return;
      if (act == ACT_REQUEST) begin
         if (ring_state[s] == SEAT_EATING)
            return;
         ring_state[s] = SEAT_HUNGRY;
         offer_bowl(s);
      end else begin
         // a release by a seat that is not eating returns nothing
         if (ring_state[s] == SEAT_EATING && free_bowls < TOKEN_MAX)
            free_bowls = free_bowls + 1'b1;
         ring_state[s] = SEAT_THINKING;
         offer_bowl(left_seat(s));
         offer_bowl(right_seat(s));
      end
      if (expected_grants.size() > queued_n) begin
         g      = expected_grants.pop_back();
         g.last = 1'b1;
         expected_grants.push_back(g);
      end
   endfunction

   // The free pool is only reloaded while nobody eats.
   function automatic void load_bowl_count(input logic [TOKEN_W-1:0] value);
      bit eating;
      eating   = 1'b0;
      bowl_reg = value;
      for (int i = 0; i < SEATS; i++)
         if (ring_state[i] == SEAT_EATING)
            eating = 1'b1;
      if (!eating)
         free_bowls = bowl_reg;
   endfunction

   // Request driver: holds valid across back-to-back items.
   always @(negedge clock) begin
      seat_cmd_type c;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            c = pending_cmds.pop_front();
            req_if.valid  <= 1'b1;
            req_if.action <= c.action;
            req_if.seat   <= c.seat;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result receiver with random stalls and one long hold-off.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: check delivered grants, then predict from accepted items.
   always @(posedge clock) begin
      grant_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_grants.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected grant: seat %0d tokens %0d last %0d",
                           rsp_if.granted_seat, rsp_if.tokens_left, rsp_if.last);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_if.granted_seat !== want.seat || rsp_if.tokens_left !== want.tokens ||
                   rsp_if.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: want seat %0d tokens %0d last %0d, got %0d %0d %0d",
                              want.seat, want.tokens, want.last,
                              rsp_if.granted_seat, rsp_if.tokens_left, rsp_if.last);
               end
            end
         end
         if (req_if.valid && req_if.ready)
            predict_grants(req_if.action, req_if.seat);
         if (csr_if.valid && csr_if.ready)
            load_bowl_count(csr_if.bowl_count);
      end
      req_fired <= !reset && req_if.valid && req_if.ready;
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_cmd(input logic act, input int s);
      seat_cmd_type c;
      c.action = act;
      c.seat   = s[SEAT_W-1:0];
      pending_cmds.push_back(c);
   endtask

   // Return every seat to thinking so the next bowl count write reloads the pool.
   task automatic release_all();
      for (int i = 0; i < SEATS; i++)
         push_cmd(ACT_RELEASE, i);
   endtask

   // Mostly in-range seats, with some out-of-range ones mixed in.
   task automatic push_random(input int n);
      int counted;
      int s;
      counted = 0;
      while (counted < n) begin
         if ($urandom_range(0, 9) == 0) begin
            s = $urandom_range(SEATS, (1 << SEAT_W) - 1);
         end else begin
            s = $urandom_range(0, SEATS - 1);
         end
         counted++;
         push_cmd($urandom_range(0, 1) ? ACT_RELEASE : ACT_REQUEST, s);
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_if.valid || expected_grants.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bowl_count(input logic [TOKEN_W-1:0] value);
      @(negedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.bowl_count <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = ACT_REQUEST;
      req_if.seat       = '0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.bowl_count = '0;
      bowl_reg          = BOWL_RESET;
      free_bowls        = BOWL_RESET;
      for (int i = 0; i < SEATS; i++)
         ring_state[i] = SEAT_THINKING;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset bowl count
      send_idle_pct = 11;
      recv_idle_pct = 69;
      push_cmd(ACT_REQUEST, 0);
      push_cmd(ACT_REQUEST, 0);          // eating seat asks again: ignored
      push_cmd(ACT_REQUEST, 1);          // blocked by a neighbor
      push_cmd(ACT_REQUEST, 1);          // hungry seat tested again
      push_cmd(ACT_REQUEST, SEATS - 1);  // wraps to seat 0
      push_cmd(ACT_REQUEST, 2);
      push_cmd(ACT_RELEASE, 0);
      push_cmd(ACT_RELEASE, 3);          // release while not eating
      push_cmd(ACT_RELEASE, 2);
      push_cmd(ACT_RELEASE, SEATS - 1);
      push_cmd(ACT_REQUEST, 0);
      push_cmd(ACT_REQUEST, 2);
      push_cmd(ACT_RELEASE, 1);          // both neighbors may be granted
      push_cmd(ACT_REQUEST, 15);         // out-of-range seats
      push_cmd(ACT_RELEASE, SEATS);
      push_cmd(ACT_RELEASE, 15);
      push_cmd(ACT_REQUEST, 10);
      push_cmd(ACT_REQUEST, 3);
      push_cmd(ACT_REQUEST, 4);
      push_cmd(ACT_RELEASE, 0);
      release_all();
      wait_drained();

      write_bowl_count(TOKEN_MAX);
      push_random(300);
      release_all();
      wait_drained();

      // sender idles more than the receiver from here
      send_idle_pct = 69;
      recv_idle_pct = 11;
      write_bowl_count('0);              // empty pool: nobody can be granted
      push_random(60);
      wait_drained();

      write_bowl_count(4'd1);
      push_random(300);
      wait_drained();

      // no idling; receiver holds off once so the block backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_bowl_count($urandom_range(2, 14));  // seats may still be eating
      push_random(350);
      hold_arm = 1'b1;
      wait_drained();

      if (fail_count == 0 && expected_grants.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/core/rnea_pkg.sv
rtl/core/rnea_if.sv
rtl/core/rnea_datapath.sv
rtl/core/rnea_ctrl.sv
rtl/core/ring_neighbor_exclusion_arbiter_unit.sv
rtl/core/rnea_checker.sv
tb/sv/tb.sv
